[sv/sts_pkg.sv]
// ============================================================================
// sts_pkg: shared types and constants of the stereo transient shaper
// Fixed field widths, register indexes, reset values, state encodings and
// the control and status bundles exchanged between the lanes and the top.
// ============================================================================
package sts_pkg;

    // fixed field widths
    localparam int GAIN_W     = 18;  // trim gain, unsigned Q2.16
    localparam int WEIGHT_W   = 24;  // follower weight, unsigned Q0.24
    localparam int TRIM_FRAC  = 16;  // fractional bits of the trimmed sample
    localparam int ENV_GUARD  = 8;   // extra fractional bits of the envelopes
    localparam int RATIO_INT  = 6;   // integer bits of the envelope ratio
    localparam int CHUNK_W    = 24;  // operand slice taken by the lane multipliers

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_TRIM   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_WEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_WEIGHT = 2'd2;

    localparam logic [GAIN_W-1:0]   GAIN_RESET = 18'd65536;
    localparam logic [WEIGHT_W-1:0] FAST_RESET = 24'd1276551;
    localparam logic [WEIGHT_W-1:0] SLOW_RESET = 24'd1275370;

    // lane sequencer
    typedef enum logic [3:0] {
        L_IDLE,
        L_ABS,
        L_DIFF,
        L_EMUL,
        L_EUPD,
        L_DINIT,
        L_DIV,
        L_WAIT,
        L_OMUL,
        L_SAT,
        L_DONE
    } lane_state_t;

    // top level sequencer
    typedef enum logic [1:0] {
        T_IDLE,
        T_ENV,
        T_OUT,
        T_PUSH
    } top_state_t;

    // top to lane
    typedef struct packed {
        logic start;     // beat accepted, sample valid this cycle
        logic bank;      // one selects follower bank a
        logic shape_go;  // resolved ratio valid this cycle
    } lane_ctl_t;

    // lane to top
    typedef struct packed {
        logic busy;
        logic div_done;   // envelopes updated, ratio known
        logic has_ratio;  // slow envelope nonzero, quotient is fresh
        logic out_done;   // shaped sample ready
    } lane_sts_t;

endpackage

[sv/stereo_transient_shaper_core.sv]
// ============================================================================
// stereo_transient_shaper_core: envelope ratio transient designer, stereo
// Two channel lanes follow fast and slow envelopes of the trimmed samples,
// a merge stage resolves the fast/slow ratios, and the lanes scale each
// trimmed sample by its ratio with saturation to the sample width.
// ============================================================================
//
//  channel   direction  handshake             payload
//  s_*       in         s_tvalid / s_tready   s_tdata: left_sample, right_sample
//  m_*       out        m_tvalid / m_tready   m_tdata: left_out, right_out
//  cfg_*     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
//  one stereo beat is processed at a time; most of the time from accept to
//  result goes to the restoring divider (one quotient bit per cycle,
//  6 + RATIO_FRAC_BITS steps); the next beat is taken the cycle after the
//  result loads into the output register
//  a zero slow envelope or a saturated ratio skips that lane's divider; the
//  beat gets shorter only when both lanes skip it
//  the output register holds a result while the lanes work on the next beat
//  reset (aresetn low, synchronous) clears envelopes and last ratio, sets
//  the bank bit and loads the register defaults; cfg_ready is always high
//
module stereo_transient_shaper_core #(
    parameter int SAMPLE_BITS     = 24,
    parameter int RATIO_FRAC_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,  // left_sample, right_sample
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,  // left_out, right_out, zero pad
    // register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sts_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int RATIO_W = sts_pkg::RATIO_INT + RATIO_FRAC_BITS;

    sts_pkg::top_state_t state_reg, state_next;

    // configuration registers
    logic [sts_pkg::GAIN_W-1:0]   gain_reg;
    logic [sts_pkg::WEIGHT_W-1:0] fast_w_reg;
    logic [sts_pkg::WEIGHT_W-1:0] slow_w_reg;

    // alternating follower bank, one means bank a
    logic bank_reg;

    // output register
    logic               m_tvalid_reg;
    logic [TDATA_W-1:0] m_tdata_reg;

    sts_pkg::lane_ctl_t lane_ctl;
    sts_pkg::lane_sts_t l_sts, r_sts;

    logic [RATIO_W-1:0]     l_quot, r_quot, l_ratio, r_ratio;
    logic [SAMPLE_BITS-1:0] l_shaped, r_shaped;
    logic                   accept, shape_go, out_slot, load_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= sts_pkg::GAIN_RESET;
            fast_w_reg <= sts_pkg::FAST_RESET;
            slow_w_reg <= sts_pkg::SLOW_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                sts_pkg::REG_GAIN_TRIM:   gain_reg   <= cfg_data[sts_pkg::GAIN_W-1:0];
                sts_pkg::REG_FAST_WEIGHT: fast_w_reg <= cfg_data;
                sts_pkg::REG_SLOW_WEIGHT: slow_w_reg <= cfg_data;
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // sequencer: take a beat, wait for both ratios, wait for both results and a free output slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sts_pkg::T_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = state_reg == sts_pkg::T_IDLE;
    assign accept   = s_tvalid && s_tready;
    assign out_slot = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        shape_go   = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            sts_pkg::T_IDLE: begin
                if (accept) state_next = sts_pkg::T_ENV;
            end
            sts_pkg::T_ENV: begin
                // a lane that skipped its divider waits here for the other one
                if (l_sts.div_done && r_sts.div_done) begin
                    shape_go   = 1'b1;
                    state_next = sts_pkg::T_OUT;
                end
            end
            sts_pkg::T_OUT: begin
                if (l_sts.out_done && r_sts.out_done) begin
                    if (out_slot) begin
                        load_out   = 1'b1;
                        state_next = sts_pkg::T_IDLE;
                    end else begin
                        state_next = sts_pkg::T_PUSH;
                    end
                end
            end
            sts_pkg::T_PUSH: begin
                // lanes idle, their result registers hold the shaped samples
                if (out_slot) begin
                    load_out   = 1'b1;
                    state_next = sts_pkg::T_IDLE;
                end
            end
            default: state_next = sts_pkg::T_IDLE;
        endcase
    end

    assign lane_ctl.start    = accept;
    assign lane_ctl.bank     = bank_reg;
    assign lane_ctl.shape_go = shape_go;

    // bank flips once per finished beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_reg <= 1'b1;
        end else if (load_out) begin
            bank_reg <= ~bank_reg;
        end
    end

    // left lane
    sts_lane #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_lane_left (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (lane_ctl),
        .sample      ($signed(s_tdata[SAMPLE_BITS-1:0])),
        .gain_trim   (gain_reg),
        .fast_weight (fast_w_reg),
        .slow_weight (slow_w_reg),
        .ratio       (l_ratio),
        .sts         (l_sts),
        .quotient    (l_quot),
        .shaped      (l_shaped)
    );

    // right lane
    sts_lane #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_lane_right (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (lane_ctl),
        .sample      ($signed(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
        .gain_trim   (gain_reg),
        .fast_weight (fast_w_reg),
        .slow_weight (slow_w_reg),
        .ratio       (r_ratio),
        .sts         (r_sts),
        .quotient    (r_quot),
        .shaped      (r_shaped)
    );

    // ratio fallback and last ratio memory
    sts_merge #(
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .update  (shape_go),
        .l_sts   (l_sts),
        .r_sts   (r_sts),
        .l_quot  (l_quot),
        .r_quot  (r_quot),
        .l_ratio (l_ratio),
        .r_ratio (r_ratio)
    );

    // output beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= TDATA_W'({r_shaped, l_shaped});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // both lanes start shaping on the same cycle, so they finish together
    a_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        l_sts.out_done == r_sts.out_done)
        else $error("lanes out of step");

    // a new beat must find both lanes idle
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> (!l_sts.busy && !r_sts.busy))
        else $error("beat accepted while a lane is busy");

    // every finished beat flips the follower bank
    a_bank_flip: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> (bank_reg != $past(bank_reg)))
        else $error("bank did not toggle after a result");

endmodule

[sv/sts_lane.sv]
// ============================================================================
// sts_lane: one channel of the transient shaper
// Trims the sample, runs the fast and slow followers of the selected bank
// through sliced multipliers, divides fast by slow bit by bit and finally
// scales the trimmed magnitude by the ratio handed back by the merge stage.
// ============================================================================
module sts_lane #(
    parameter int SAMPLE_BITS     = 24,
    parameter int RATIO_FRAC_BITS = 16
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  sts_pkg::lane_ctl_t                              ctl,
    input  logic signed [SAMPLE_BITS-1:0]                   sample,
    input  logic [sts_pkg::GAIN_W-1:0]                      gain_trim,
    input  logic [sts_pkg::WEIGHT_W-1:0]                    fast_weight,
    input  logic [sts_pkg::WEIGHT_W-1:0]                    slow_weight,
    input  logic [sts_pkg::RATIO_INT+RATIO_FRAC_BITS-1:0]   ratio,
    output sts_pkg::lane_sts_t                              sts,
    output logic [sts_pkg::RATIO_INT+RATIO_FRAC_BITS-1:0]   quotient,
    output logic signed [SAMPLE_BITS-1:0]                   shaped
);

    localparam int T_W       = SAMPLE_BITS + sts_pkg::GAIN_W + 1;
    localparam int MAG_W     = SAMPLE_BITS + sts_pkg::GAIN_W - 1;
    localparam int ENV_W     = MAG_W + sts_pkg::ENV_GUARD;
    localparam int RATIO_W   = sts_pkg::RATIO_INT + RATIO_FRAC_BITS;
    localparam int NCH       = (ENV_W + sts_pkg::CHUNK_W - 1) / sts_pkg::CHUNK_W;
    localparam int DE_W      = NCH * sts_pkg::CHUNK_W;
    localparam int MB_W      = (sts_pkg::WEIGHT_W > RATIO_W) ? sts_pkg::WEIGHT_W : RATIO_W;
    localparam int PROD_W    = sts_pkg::CHUNK_W + MB_W;
    localparam int ACC_W     = DE_W + MB_W;
    localparam int DEN_W     = ENV_W + sts_pkg::RATIO_INT;
    localparam int CNT_W     = $clog2(RATIO_W + 1);
    localparam int OUT_SHIFT = sts_pkg::TRIM_FRAC + RATIO_FRAC_BITS;
    localparam int P_W       = ACC_W - OUT_SHIFT;

    sts_pkg::lane_state_t state_reg, state_next;

    logic                 bank_reg;
    logic [T_W-1:0]       t_reg;
    logic [MAG_W-1:0]     mag_reg;
    logic                 neg_reg;
    logic [ENV_W-1:0]     fenv_reg [2];
    logic [ENV_W-1:0]     senv_reg [2];
    logic [DE_W-1:0]      fd_reg, sd_reg;
    logic                 f_up_reg, s_up_reg;
    logic [MB_W-1:0]      mb_reg;
    logic [PROD_W-1:0]    fprod_reg, sprod_reg;
    logic [ACC_W-1:0]     facc_reg, sacc_reg;
    logic [DEN_W-1:0]     rem_reg, den_reg;
    logic [RATIO_W-1:0]   quo_reg;
    logic                 has_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [SAMPLE_BITS-1:0] shaped_reg;

    logic                 sel;
    logic [T_W-1:0]       t_prod, t_abs;
    logic [ENV_W-1:0]     fcur, scur, tgt, fdiff, sdiff, fstep, sstep, fenv_next, senv_next;
    logic                 f_ge, s_ge, slow_zero, sat_ratio, div_ge, last_chunk;
    logic [PROD_W-1:0]    fmul, smul;
    logic [DEN_W:0]       rem2, den2, rem_sub;
    logic [P_W-1:0]       prod_p, lim, lim_m1, p_neg_clip, p_pos_clip;
    logic [SAMPLE_BITS-1:0] sat_val;

    // bank a sits at entry 0 and is used while the bank bit is one
    assign sel  = ~bank_reg;
    assign fcur = fenv_reg[sel];
    assign scur = senv_reg[sel];

    assign t_prod = T_W'(sample) * T_W'($signed({1'b0, gain_trim}));
    assign t_abs  = t_reg[T_W-1] ? (~t_reg + T_W'(1)) : t_reg;

    // follower step: distance to the target, then weight * distance >> 24
    assign tgt   = {mag_reg, {sts_pkg::ENV_GUARD{1'b0}}};
    assign f_ge  = tgt >= fcur;
    assign s_ge  = tgt >= scur;
    assign fdiff = f_ge ? (tgt - fcur) : (fcur - tgt);
    assign sdiff = s_ge ? (tgt - scur) : (scur - tgt);

    assign fmul = PROD_W'(fd_reg[DE_W-1 -: sts_pkg::CHUNK_W]) * PROD_W'(mb_reg);
    assign smul = PROD_W'(sd_reg[DE_W-1 -: sts_pkg::CHUNK_W]) * PROD_W'(slow_weight);
    assign last_chunk = cnt_reg == CNT_W'(NCH);

    assign fstep     = facc_reg[sts_pkg::WEIGHT_W +: ENV_W];
    assign sstep     = sacc_reg[sts_pkg::WEIGHT_W +: ENV_W];
    assign fenv_next = f_up_reg ? (fcur + fstep) : (fcur - fstep);
    assign senv_next = s_up_reg ? (scur + sstep) : (scur - sstep);

    // restoring division of fast by slow << 6
    assign slow_zero = scur == '0;
    assign sat_ratio = DEN_W'(fcur) >= {scur, {sts_pkg::RATIO_INT{1'b0}}};
    assign rem2      = {rem_reg, 1'b0};
    assign den2      = {1'b0, den_reg};
    assign div_ge    = rem2 >= den2;
    assign rem_sub   = rem2 - den2;

    // output scaling and saturation
    assign prod_p     = facc_reg[ACC_W-1:OUT_SHIFT];
    assign lim        = P_W'(1) << (SAMPLE_BITS - 1);
    assign lim_m1     = lim - P_W'(1);
    assign p_neg_clip = (prod_p > lim) ? lim : prod_p;
    assign p_pos_clip = (prod_p > lim_m1) ? lim_m1 : prod_p;
    assign sat_val    = neg_reg ? SAMPLE_BITS'(P_W'(0) - p_neg_clip)
                                : SAMPLE_BITS'(p_pos_clip);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sts_pkg::L_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sts_pkg::L_IDLE: begin
                if (ctl.start) state_next = sts_pkg::L_ABS;
            end
            sts_pkg::L_ABS:   state_next = sts_pkg::L_DIFF;
            sts_pkg::L_DIFF:  state_next = sts_pkg::L_EMUL;
            sts_pkg::L_EMUL: begin
                if (last_chunk) state_next = sts_pkg::L_EUPD;
            end
            sts_pkg::L_EUPD:  state_next = sts_pkg::L_DINIT;
            sts_pkg::L_DINIT: begin
                if (slow_zero || sat_ratio) begin
                    state_next = sts_pkg::L_WAIT;
                end else begin
                    state_next = sts_pkg::L_DIV;
                end
            end
            sts_pkg::L_DIV: begin
                if (cnt_reg == CNT_W'(RATIO_W - 1)) state_next = sts_pkg::L_WAIT;
            end
            sts_pkg::L_WAIT: begin
                if (ctl.shape_go) state_next = sts_pkg::L_OMUL;
            end
            sts_pkg::L_OMUL: begin
                if (last_chunk) state_next = sts_pkg::L_SAT;
            end
            sts_pkg::L_SAT:   state_next = sts_pkg::L_DONE;
            sts_pkg::L_DONE:  state_next = sts_pkg::L_IDLE;
            default:          state_next = sts_pkg::L_IDLE;
        endcase
    end

    assign sts.busy      = state_reg != sts_pkg::L_IDLE;
    assign sts.div_done  = state_reg == sts_pkg::L_WAIT;
    assign sts.has_ratio = has_reg;
    assign sts.out_done  = state_reg == sts_pkg::L_DONE;
    assign quotient      = quo_reg;
    assign shaped        = $signed(shaped_reg);

    // follower banks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 2; i++) begin
                fenv_reg[i] <= '0;
                senv_reg[i] <= '0;
            end
        end else if (state_reg == sts_pkg::L_EUPD) begin
            fenv_reg[sel] <= fenv_next;
            senv_reg[sel] <= senv_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            sts_pkg::L_IDLE: begin
                if (ctl.start) begin
                    t_reg    <= t_prod;
                    bank_reg <= ctl.bank;
                end
            end
            sts_pkg::L_ABS: begin
                mag_reg <= MAG_W'(t_abs);
                neg_reg <= t_reg[T_W-1];
            end
            sts_pkg::L_DIFF: begin
                fd_reg    <= DE_W'(fdiff);
                sd_reg    <= DE_W'(sdiff);
                f_up_reg  <= f_ge;
                s_up_reg  <= s_ge;
                mb_reg    <= MB_W'(fast_weight);
                fprod_reg <= '0;
                sprod_reg <= '0;
                facc_reg  <= '0;
                sacc_reg  <= '0;
                cnt_reg   <= '0;
            end
            sts_pkg::L_EMUL, sts_pkg::L_OMUL: begin
                // top slice first, accumulate one product behind the multiplier
                fprod_reg <= fmul;
                sprod_reg <= smul;
                fd_reg    <= fd_reg << sts_pkg::CHUNK_W;
                sd_reg    <= sd_reg << sts_pkg::CHUNK_W;
                facc_reg  <= (facc_reg << sts_pkg::CHUNK_W) + ACC_W'(fprod_reg);
                sacc_reg  <= (sacc_reg << sts_pkg::CHUNK_W) + ACC_W'(sprod_reg);
                cnt_reg   <= cnt_reg + CNT_W'(1);
            end
            sts_pkg::L_DINIT: begin
                has_reg <= !slow_zero;
                quo_reg <= sat_ratio ? '1 : '0;
                rem_reg <= DEN_W'(fcur);
                den_reg <= {scur, {sts_pkg::RATIO_INT{1'b0}}};
                cnt_reg <= '0;
            end
            sts_pkg::L_DIV: begin
                rem_reg <= div_ge ? DEN_W'(rem_sub) : DEN_W'(rem2);
                quo_reg <= {quo_reg[RATIO_W-2:0], div_ge};
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            sts_pkg::L_WAIT: begin
                if (ctl.shape_go) begin
                    mb_reg    <= MB_W'(ratio);
                    fd_reg    <= DE_W'(mag_reg);
                    sd_reg    <= '0;
                    fprod_reg <= '0;
                    sprod_reg <= '0;
                    facc_reg  <= '0;
                    sacc_reg  <= '0;
                    cnt_reg   <= '0;
                end
            end
            sts_pkg::L_SAT: begin
                shaped_reg <= sat_val;
            end
            default: ;
        endcase
    end

endmodule

[sv/sts_merge.sv]
// ============================================================================
// sts_merge: ratio resolution across the two lanes
// Picks the ratio each channel applies, falling back to the last ratio
// computed when a lane's slow envelope is zero; left resolves before right.
// ============================================================================
module sts_merge #(
    parameter int RATIO_FRAC_BITS = 16
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            update,
    input  sts_pkg::lane_sts_t                              l_sts,
    input  sts_pkg::lane_sts_t                              r_sts,
    input  logic [sts_pkg::RATIO_INT+RATIO_FRAC_BITS-1:0]   l_quot,
    input  logic [sts_pkg::RATIO_INT+RATIO_FRAC_BITS-1:0]   r_quot,
    output logic [sts_pkg::RATIO_INT+RATIO_FRAC_BITS-1:0]   l_ratio,
    output logic [sts_pkg::RATIO_INT+RATIO_FRAC_BITS-1:0]   r_ratio
);

    localparam int RATIO_W = sts_pkg::RATIO_INT + RATIO_FRAC_BITS;

    logic [RATIO_W-1:0] last_ratio_reg;

    // right may pick up the ratio the left lane just produced
    assign l_ratio = l_sts.has_ratio ? l_quot : last_ratio_reg;
    assign r_ratio = r_sts.has_ratio ? r_quot : l_ratio;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_ratio_reg <= '0;
        end else if (update) begin
            last_ratio_reg <= r_ratio;
        end
    end

endmodule

[tb/tb_stereo_transient_shaper_core.sv]
// ============================================================================
// tb_stereo_transient_shaper_core: self-checking bench of the stereo shaper
// Feeds stereo sample beats through the stream ports, writes the trim and
// follower weights between phases, and checks every result beat against a
// bit-exact envelope ratio predictor kept in a small scoreboard class.
// ============================================================================
module tb_stereo_transient_shaper_core;

    localparam int SAMPLE_BITS     = 24;
    localparam int RATIO_FRAC_BITS = 16;
    localparam int STALL_LIMIT     = 4000;  // cycles with no beat on any port
    localparam int HOLD_CYCLES     = 400;   // long receiver hold-off
    localparam int PHASE_BEATS     = 376;

    // index that maps to no register, written to check it is ignored
    localparam logic [sts_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // tdata layout: left in the low bits, right above it
    typedef struct packed {
        sample_t right;
        sample_t left;
    } stereo_t;

    localparam sample_t S_MAX = 24'sh7FFFFF;
    localparam sample_t S_MIN = 24'sh800000;

    // ------------------------------------------------------------------------
    // envelope ratio predictor and the queue of shaped beats still to come
    // ------------------------------------------------------------------------
    class shaped_sample_board;
        bit [sts_pkg::GAIN_W-1:0]   gain;
        bit [sts_pkg::WEIGHT_W-1:0] w_fast;
        bit [sts_pkg::WEIGHT_W-1:0] w_slow;
        bit [63:0]                  env_fast[4];
        bit [63:0]                  env_slow[4];
        bit                         bank_a;
        bit [63:0]                  ratio_hold;
        stereo_t                    shaped_q[$];
        int                         mismatches;
        int                         beats_checked;

        function new();
            gain       = sts_pkg::GAIN_RESET;
            w_fast     = sts_pkg::FAST_RESET;
            w_slow     = sts_pkg::SLOW_RESET;
            bank_a     = 1'b1;
            ratio_hold = '0;
            for (int i = 0; i < 4; i++) begin
                env_fast[i] = '0;
                env_slow[i] = '0;
            end
            mismatches    = 0;
            beats_checked = 0;
        endfunction

        function void set_reg(bit [sts_pkg::CFG_IDX_W-1:0] idx,
                              bit [sts_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                sts_pkg::REG_GAIN_TRIM:   gain   = val[sts_pkg::GAIN_W-1:0];
                sts_pkg::REG_FAST_WEIGHT: w_fast = val[sts_pkg::WEIGHT_W-1:0];
                sts_pkg::REG_SLOW_WEIGHT: w_slow = val[sts_pkg::WEIGHT_W-1:0];
                default: ;
            endcase
        endfunction

        // floor(a * w / 2^24), split so the products stay inside 64 bits
        function bit [63:0] weigh(bit [63:0] a, bit [63:0] w);
            return (a >> sts_pkg::WEIGHT_W) * w
                   + (((a & 64'hFFFFFF) * w) >> sts_pkg::WEIGHT_W);
        endfunction

        function bit [63:0] track(bit [63:0] env, bit [63:0] mag, bit [63:0] w);
            if (mag >= env)
                return env + weigh(mag - env, w);
            return env - weigh(env - mag, w);
        endfunction

        // fast/slow as unsigned Q6.RATIO_FRAC_BITS, saturated
        function bit [63:0] env_ratio(bit [63:0] f, bit [63:0] s);
            bit [63:0] q;
            bit [63:0] r;
            if (f >= (s << sts_pkg::RATIO_INT))
                return (64'd1 << (sts_pkg::RATIO_INT + RATIO_FRAC_BITS)) - 1;
            q = f / s;
            r = f % s;
            for (int i = 0; i < RATIO_FRAC_BITS; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= s) begin
                    r = r - s;
                    q[0] = 1'b1;
                end
            end
            return q;
        endfunction

        function sample_t shape_channel(sample_t x, int base);
            longint    t;
            bit        neg;
            bit [63:0] mag;
            bit [63:0] p;
            bit [63:0] lim;
            int        idx;
            t   = longint'(x) * longint'(gain);
            neg = (t < 0);
            mag = neg ? 64'(-t) : 64'(t);
            idx = base + (bank_a ? 0 : 1);
            env_fast[idx] = track(env_fast[idx], mag << sts_pkg::ENV_GUARD, w_fast);
            env_slow[idx] = track(env_slow[idx], mag << sts_pkg::ENV_GUARD, w_slow);
            if (env_slow[idx] != 0)
                ratio_hold = env_ratio(env_fast[idx], env_slow[idx]);
            p = ((mag >> sts_pkg::TRIM_FRAC) * ratio_hold
                 + (((mag & 64'hFFFF) * ratio_hold) >> sts_pkg::TRIM_FRAC))
                >> RATIO_FRAC_BITS;
            lim = 64'd1 << (SAMPLE_BITS - 1);
            if (neg) begin
                if (p > lim)
                    p = lim;
                p = 64'd0 - p;
                return p[SAMPLE_BITS-1:0];
            end
            if (p > lim - 1)
                p = lim - 1;
            return p[SAMPLE_BITS-1:0];
        endfunction

        function void note_sample(stereo_t in);
            stereo_t o;
            o.left  = shape_channel(in.left, 0);
            o.right = shape_channel(in.right, 2);
            bank_a  = !bank_a;
            shaped_q.push_back(o);
        endfunction

        function void check_result(stereo_t got);
            stereo_t want;
            if (shaped_q.size() == 0) begin
                $error("result beat with no pending sample: left %0d right %0d",
                       got.left, got.right);
                mismatches++;
                return;
            end
            want = shaped_q.pop_front();
            beats_checked++;
            if (got.left !== want.left) begin
                $error("left_out: expected %0d, actual %0d", want.left, got.left);
                mismatches++;
            end
            if (got.right !== want.right) begin
                $error("right_out: expected %0d, actual %0d", want.right, got.right);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [47:0]                    s_tdata   = '0;  // left_sample, right_sample
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [47:0]                    m_tdata;         // left_out, right_out
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [sts_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [sts_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    always #6 aclk = ~aclk;

    stereo_transient_shaper_core #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    shaped_sample_board board = new();

    int tx_idle_pct  = 0;   // chance in a hundred that the sender skips a cycle
    int rx_idle_pct  = 0;   // same for the receiver
    bit hold_request = 1'b0;
    int hold_left    = 0;
    int stall_cycles = 0;
    int beats_in     = 0;
    int reg_writes   = 0;

    // ------------------------------------------------------------------------
    // receiver: random back-pressure, plus one long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_request) begin
            // block fills up behind this and must stall s_tready
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: every handshake is sampled here, in one place, so the order of
    // predictor updates does not depend on process scheduling
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                board.set_reg(cfg_index, cfg_data);
                reg_writes++;
            end
            if (m_tvalid && m_tready)
                board.check_result(stereo_t'(m_tdata));
            if (s_tvalid && s_tready) begin
                board.note_sample(stereo_t'(s_tdata));
                beats_in++;
            end
            // watchdog counter, cleared by any beat on any port
            if ((cfg_valid && cfg_ready) || (m_tvalid && m_tready) || (s_tvalid && s_tready))
                stall_cycles = 0;
            else
                stall_cycles = stall_cycles + 1;
        end
    end

    // watchdog: the block has stopped moving beats
    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge aclk);
        $display("tb_stereo_transient_shaper_core: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // offer one stereo beat, after a random gap, and hold it until taken;
    // tvalid stays high into the next beat when there is no gap
    task automatic send_beat(input sample_t l, input sample_t r);
        stereo_t b;
        b.left  = l;
        b.right = r;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(input logic [sts_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sts_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic load_settings(input logic [sts_pkg::CFG_DATA_W-1:0] g,
                                 input logic [sts_pkg::CFG_DATA_W-1:0] f,
                                 input logic [sts_pkg::CFG_DATA_W-1:0] s);
        write_reg(sts_pkg::REG_GAIN_TRIM, g);
        write_reg(sts_pkg::REG_FAST_WEIGHT, f);
        write_reg(sts_pkg::REG_SLOW_WEIGHT, s);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // stop offering and wait until every pending beat has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.shaped_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic sample_t signed_mag(int unsigned m);
        sample_t v;
        v = sample_t'(m);
        return $urandom_range(1) ? -v : v;
    endfunction

    // sample shapes: full random, quiet, loud, sparse transients, extremes
    function automatic sample_t pick_sample(int mode);
        case (mode)
            0: return sample_t'($urandom);
            1: return signed_mag($urandom_range(511));
            2: return signed_mag($urandom_range(24'h400000, 24'h7FFFFF));
            3: return ($urandom_range(15) == 0) ? sample_t'($urandom)
                                                : signed_mag($urandom_range(4095));
            default: begin
                case ($urandom_range(4))
                    0:       return S_MAX;
                    1:       return S_MIN;
                    2:       return 24'sd1;
                    3:       return -24'sd1;
                    default: return 24'sd0;
                endcase
            end
        endcase
    endfunction

    task automatic run_phase(input int n, input int tx_pct, input int rx_pct,
                             input bit with_hold);
        int mode;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        mode = 0;
        for (int i = 0; i < n; i++) begin
            // shapes come in bursts so the followers have time to settle
            if (i % 16 == 0)
                mode = $urandom_range(4);
            if (with_hold && i == 60)
                hold_request = 1'b1;
            send_beat(pick_sample(mode), pick_sample(mode));
        end
        drain();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 10;
        rx_idle_pct = 71;

        // tiny trim and slow weight right after reset: slow envelopes of the small
        // samples stay zero, so the ratio left from reset (zero) and later the one
        // the left channel just made are reused
        load_settings(24'd1, sts_pkg::FAST_RESET, 24'd1);
        send_beat(24'sd1, -24'sd1);
        send_beat(S_MAX, 24'sd60000);
        send_beat(24'sd0, 24'sd0);
        send_beat(S_MAX, -24'sd60000);
        drain();

        // largest trim through masking, fast weight at full scale:
        // ratio overflow and output saturation both ways; stray index ignored
        write_reg(REG_UNUSED, 24'($urandom));
        load_settings(24'hFFFFFF, 24'hFFFFFF, 24'd1);
        send_beat(S_MAX, S_MIN);
        send_beat(S_MIN, S_MAX);
        send_beat(S_MAX, -24'sd4242);
        send_beat(24'sd0, 24'sd0);
        drain();

        // zero trim, fast follower frozen, slow follower at full weight
        load_settings(24'd0, 24'd0, 24'hFFFFFF);
        send_beat(S_MAX, S_MIN);
        send_beat(24'sd12345, -24'sd12345);
        send_beat(sample_t'($urandom), sample_t'($urandom));
        drain();

        // unity trim with both followers frozen at what they hold
        load_settings(24'd65536, 24'd0, 24'd0);
        send_beat(S_MAX, S_MIN);
        send_beat(S_MIN, 24'sd1);
        send_beat(-24'sd1, S_MAX);
        send_beat(sample_t'($urandom), sample_t'($urandom));
        drain();

        // register defaults
        load_settings(sts_pkg::GAIN_RESET, sts_pkg::FAST_RESET, sts_pkg::SLOW_RESET);
        send_beat(S_MAX, S_MIN);
        send_beat(24'sd1, -24'sd1);
        send_beat(sample_t'($urandom), sample_t'($urandom));
        drain();

        // random part: sender idles lightly, receiver heavily
        load_settings($urandom_range(32768, 131072), $urandom_range(1 << 20, 1 << 22),
                      $urandom_range(1 << 12, 1 << 18));
        run_phase(PHASE_BEATS, 10, 71, 1'b0);

        // sender idles heavily, receiver lightly, full range settings
        load_settings($urandom_range(262143), $urandom_range(24'hFFFFFF),
                      $urandom_range(24'hFFFFFF));
        run_phase(PHASE_BEATS, 71, 10, 1'b0);

        // no idling, with one long receiver hold-off after beat 60
        load_settings($urandom_range(262143), $urandom_range(24'hFFFFFF),
                      $urandom_range(1, 1 << 16));
        run_phase(PHASE_BEATS, 0, 0, 1'b1);

        // let anything stray come out before judging
        repeat (48) @(posedge aclk);
        if (board.shaped_q.size() != 0) begin
            $error("%0d shaped beats never arrived", board.shaped_q.size());
            board.mismatches++;
        end

        $display("summary: %0d stereo beats in, %0d results checked, %0d register writes",
                 beats_in, board.beats_checked, reg_writes);
        $display("summary: zero and saturated ratios, frozen followers, clipping, %0d cycle hold",
                 HOLD_CYCLES);
        if (board.mismatches == 0) begin
            $display("tb_stereo_transient_shaper_core: done, clean");
        end else begin
            $display("tb_stereo_transient_shaper_core: done, errors");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/sts_pkg.sv
sv/sts_lane.sv
sv/sts_merge.sv
sv/stereo_transient_shaper_core.sv
tb/tb_stereo_transient_shaper_core.sv
